// File: src/rsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB saturation limiter package
// Shared widths, constants and the word type carried by the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsl_pkg;

   localparam int COMP_W     = 8;
   localparam int NUM_COMP   = 3;
   localparam int LIM_W      = 9;
   localparam int PROD_W     = LIM_W + COMP_W;
   localparam int REM_W      = PROD_W;
   localparam int DIV_STAGES = COMP_W / 2;

   localparam logic [LIM_W-1:0] MAX_SAT_RESET = LIM_W'(256);

   typedef logic [NUM_COMP-1:0][COMP_W-1:0] comp_vec_type;

   typedef struct packed {
      comp_vec_type                       comp;
      logic [COMP_W-1:0]                  hi;
      logic [COMP_W-1:0]                  d;
      logic                               limited;
      logic [NUM_COMP-1:0][REM_W-1:0]     rem;
      logic [NUM_COMP-1:0][COMP_W-1:0]    quo;
   } div_type;

endpackage

`default_nettype wire

// File: src/rsl_ifs.sv
// ----------------------------------------------------------------------------
// RGB saturation limiter channels
// Valid/ready channels for pixel requests, limited pixel responses and the
// saturation ceiling register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsl_req_if;
   logic                        valid;
   logic                        ready;
   logic [rsl_pkg::COMP_W-1:0]  red_in;
   logic [rsl_pkg::COMP_W-1:0]  green_in;
   logic [rsl_pkg::COMP_W-1:0]  blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface rsl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rsl_pkg::COMP_W-1:0]  red_out;
   logic [rsl_pkg::COMP_W-1:0]  green_out;
   logic [rsl_pkg::COMP_W-1:0]  blue_out;
   logic                        was_limited;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output was_limited, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input was_limited, output ready);
endinterface

interface rsl_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rsl_pkg::LIM_W-1:0]   max_saturation;

   modport source (output valid, output max_saturation, input ready);
   modport sink   (input valid, input max_saturation, output ready);
endinterface

`default_nettype wire

// File: src/rsl_front.sv
// ----------------------------------------------------------------------------
// RGB saturation limiter front end
// Three stages: extremes of the pixel, ceiling times maximum, then the
// saturation test and the rounded dividends for the three components.
// ----------------------------------------------------------------------------
`default_nettype none

module rsl_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire rsl_pkg::comp_vec_type      in_comp,
   input  wire logic [rsl_pkg::LIM_W-1:0]  in_lim,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output rsl_pkg::div_type                out_data
);

   localparam int CW = rsl_pkg::COMP_W;
   localparam int LW = rsl_pkg::LIM_W;
   localparam int PW = rsl_pkg::PROD_W;
   localparam int RW = rsl_pkg::REM_W;
   localparam int XW = PW + CW;

   typedef struct packed {
      rsl_pkg::comp_vec_type comp;
      logic [CW-1:0]         hi;
      logic [CW-1:0]         d;
      logic [LW-1:0]         lim;
   } fa_type;

   typedef struct packed {
      rsl_pkg::comp_vec_type comp;
      logic [CW-1:0]         hi;
      logic [CW-1:0]         d;
      logic [PW-1:0]         k;
   } fb_type;

   logic             a_v_ff;
   fa_type           a_ff;
   fa_type           a_in;
   logic             b_v_ff;
   fb_type           b_ff;
   fb_type           b_in;
   logic             c_v_ff;
   rsl_pkg::div_type c_ff;
   rsl_pkg::div_type c_in;
   logic             adv_a;
   logic             adv_b;
   logic             adv_c;

   assign adv_c    = !c_v_ff || out_ready;
   assign adv_b    = !b_v_ff || adv_c;
   assign adv_a    = !a_v_ff || adv_b;
   assign in_ready = adv_a;

   always_comb begin
      logic [CW-1:0] hi;
      logic [CW-1:0] lo;
      hi = in_comp[0];
      lo = in_comp[0];
      for (int n = 1; n < rsl_pkg::NUM_COMP; n++) begin
         if (in_comp[n] > hi) begin
            hi = in_comp[n];
         end
         if (in_comp[n] < lo) begin
            lo = in_comp[n];
         end
      end
      a_in.comp = in_comp;
      a_in.hi   = hi;
      a_in.d    = hi - lo;
      a_in.lim  = in_lim;
   end

   always_comb begin
      b_in.comp = a_ff.comp;
      b_in.hi   = a_ff.hi;
      b_in.d    = a_ff.d;
      b_in.k    = PW'(a_ff.lim) * PW'(a_ff.hi);
   end

   always_comb begin
      logic [XW-1:0] x;
      c_in.comp    = b_ff.comp;
      c_in.hi      = b_ff.hi;
      c_in.d       = b_ff.d;
      c_in.limited = (b_ff.d != '0) && (PW'({b_ff.d, 8'h00}) > b_ff.k);
      c_in.quo     = '0;
      for (int n = 0; n < rsl_pkg::NUM_COMP; n++) begin
         x = XW'(b_ff.hi - b_ff.comp[n]) * XW'(b_ff.k) + XW'({b_ff.d, 7'h00});
         c_in.rem[n] = x[XW-1 -: RW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_v_ff <= in_valid;
         end
         if (adv_b) begin
            b_v_ff <= a_v_ff;
         end
         if (adv_c) begin
            c_v_ff <= b_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && in_valid) begin
         a_ff <= a_in;
      end
      if (adv_b && a_v_ff) begin
         b_ff <= b_in;
      end
      if (adv_c && b_v_ff) begin
         c_ff <= c_in;
      end
   end

   assign out_valid = c_v_ff;
   assign out_data  = c_ff;

endmodule

`default_nettype wire

// File: src/rsl_divider.sv
// ----------------------------------------------------------------------------
// RGB saturation limiter divider
// Pipelined restoring division of the three dividends by the pixel's spread,
// two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsl_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire rsl_pkg::div_type  in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output rsl_pkg::div_type       out_data
);

   localparam int NS = rsl_pkg::DIV_STAGES;
   localparam int RW = rsl_pkg::REM_W;
   localparam int CW = rsl_pkg::COMP_W;

   logic             stage_valid [NS];
   rsl_pkg::div_type stage_data  [NS];
   logic             adv         [NS+1];

   always_comb begin
      adv[NS] = out_ready;
      for (int j = NS - 1; j >= 0; j--) begin
         adv[j] = !stage_valid[j] || adv[j+1];
      end
   end

   assign in_ready = adv[0];

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam int B1 = CW - 1 - 2 * j;
      localparam int B0 = B1 - 1;

      logic             src_valid;
      rsl_pkg::div_type src;
      logic             v_ff;
      rsl_pkg::div_type st_ff;
      rsl_pkg::div_type st_in;

      if (j == 0) begin : g_first
         assign src_valid = in_valid;
         assign src       = in_data;
      end else begin : g_next
         assign src_valid = stage_valid[j-1];
         assign src       = stage_data[j-1];
      end

      always_comb begin
         logic [RW-1:0] rem;
         logic [RW-1:0] sh1;
         logic [RW-1:0] sh0;
         st_in = src;
         sh1   = RW'(src.d) << B1;
         sh0   = RW'(src.d) << B0;
         for (int n = 0; n < rsl_pkg::NUM_COMP; n++) begin
            rem = src.rem[n];
            if (rem >= sh1) begin
               rem = rem - sh1;
               st_in.quo[n][B1] = 1'b1;
            end
            if (rem >= sh0) begin
               rem = rem - sh0;
               st_in.quo[n][B0] = 1'b1;
            end
            st_in.rem[n] = rem;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv[j]) begin
            v_ff <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j] && src_valid) begin
            st_ff <= st_in;
         end
      end

      assign stage_valid[j] = v_ff;
      assign stage_data[j]  = st_ff;
   end

   assign out_valid = stage_valid[NS-1];
   assign out_data  = stage_data[NS-1];

endmodule

`default_nettype wire

// File: src/rgb_saturation_limiter_top.sv
// ----------------------------------------------------------------------------
// RGB saturation limiter
// Clamps the HSV saturation of each pixel to a programmable ceiling while
// keeping hue and value.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         red_in, green_in, blue_in
//  rsp      out        red_out, green_out, blue_out, was_limited
//  csr      in         max_saturation (always ready)
//
// One word is accepted per clock when not stalled; each request passes
// through three front-end stages, four divider stages and the output
// register. Each stage holds its word under back-pressure and takes a new one
// once it empties, so bubbles close up and nothing is lost or repeated.
// Reset empties the pipeline and sets the ceiling to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_saturation_limiter_top (
   input  wire logic  clock,
   input  wire logic  reset,
   rsl_req_if.sink    req,
   rsl_rsp_if.source  rsp,
   rsl_csr_if.sink    csr
);

   localparam int CW = rsl_pkg::COMP_W;

   typedef struct packed {
      rsl_pkg::comp_vec_type comp;
      logic                  limited;
   } rsp_type;

   logic [rsl_pkg::LIM_W-1:0] max_sat_ff;
   logic                      front_valid;
   logic                      front_ready;
   rsl_pkg::div_type          front_data;
   logic                      div_valid;
   logic                      div_ready;
   rsl_pkg::div_type          div_data;
   logic                      rsp_v_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      adv_out;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sat_ff <= rsl_pkg::MAX_SAT_RESET;
      end else if (csr.valid) begin
         max_sat_ff <= csr.max_saturation;
      end
   end

   rsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_comp   ({req.blue_in, req.green_in, req.red_in}),
      .in_lim    (max_sat_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   rsl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign adv_out   = !rsp_v_ff || rsp.ready;
   assign div_ready = adv_out;

   always_comb begin
      rsp_in.limited = div_data.limited;
      for (int n = 0; n < rsl_pkg::NUM_COMP; n++) begin
         if (div_data.limited) begin
            rsp_in.comp[n] = CW'(div_data.hi - div_data.quo[n]);
         end else begin
            rsp_in.comp[n] = div_data.comp[n];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && div_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid       = rsp_v_ff;
   assign rsp.red_out     = rsp_ff.comp[0];
   assign rsp.green_out   = rsp_ff.comp[1];
   assign rsp.blue_out    = rsp_ff.comp[2];
   assign rsp.was_limited = rsp_ff.limited;

endmodule

`default_nettype wire
